// ----- sv/mtis_pkg.sv -----
// Shared types and constants for the monotone table interval search block.
`timescale 1ns / 1ps

package mtis_pkg;

	// Width of one level key.
	localparam int KEY_W = 63;

	// Width of the entry index and of the interval index.
	localparam int IDX_W = 8;

	// Width of a level count, which can reach 256.
	localparam int CNT_W = 9;

	// Largest table that the eight-bit entry index can address.
	localparam int INDEX_SPAN = 256;

	// Configuration register indexes.
	localparam logic [7:0] CFG_LEVEL_COUNT = 8'd0;
	localparam logic [7:0] CFG_DESCENDING = 8'd1;

	// Input operation codes.
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// Reset value of the level count register.
	localparam logic [CNT_W-1:0] LEVEL_COUNT_RESET = 9'd256;

	// Outcome of one comparison of a table entry against the key.
	typedef struct packed {
		logic lt;
		logic gt;
	} cmp_res_t;

endpackage

// ----- sv/mtis_cmp.sv -----
// Shared magnitude comparator of a table entry against the working key.
`timescale 1ns / 1ps

module mtis_cmp (
	input  logic [mtis_pkg::KEY_W-1:0] entry,
	input  logic [mtis_pkg::KEY_W-1:0] key,
	output mtis_pkg::cmp_res_t         res
);

	// Both relations come from the same unsigned compare of the two words.
	always_comb begin
		res.lt = (entry < key);
		res.gt = (entry > key);
	end

endmodule

// ----- sv/mtis_table.sv -----
// Level table storage with one write port and one registered read port.
`timescale 1ns / 1ps

module mtis_table #(
	parameter int DEPTH = 256,
	parameter int AW = 8
) (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [AW-1:0]              wr_addr,
	input  logic [mtis_pkg::KEY_W-1:0] wr_data,
	input  logic                       rd_en,
	input  logic [AW-1:0]              rd_addr,
	output logic [mtis_pkg::KEY_W-1:0] rd_data
);

	logic [mtis_pkg::KEY_W-1:0] mem [DEPTH];
	logic [mtis_pkg::KEY_W-1:0] rd_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

// ----- sv/monotone_table_interval_search.sv -----
// Top level: table of level keys with an iterative interval search sequencer.
// A load request is written into the table at acceptance and leaves the block ready.
// A query runs through the clamp states CL0 and CL1, a sweep over all n entries and a
// done state before the next request is taken, n being the effective level count; the
// single comparator visits one table entry per cycle through the one read port, and a
// result still waiting in the output register holds the search in its last step until
// taken. Reset is asynchronous and active low: it sets the level count to 256, the
// direction to ascending and empties the output; table contents stay undefined.
`timescale 1ns / 1ps

module monotone_table_interval_search #(
	parameter int MAX_LEVELS = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write channel.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [8:0]  cfg_data,
	// Input requests.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,  // entry_index[7:0], key_value[70:8], zero pad[71]
	input  logic [0:0]  s_tuser,  // op[0]
	// Results.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata   // interval_index[7:0]
);

	localparam int AW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
	localparam int IW = (AW + 1 > mtis_pkg::CNT_W) ? AW + 1 : mtis_pkg::CNT_W;
	localparam int CAP = (MAX_LEVELS < mtis_pkg::INDEX_SPAN) ? MAX_LEVELS
		: mtis_pkg::INDEX_SPAN;
	localparam logic [mtis_pkg::CNT_W-1:0] CAP_N = mtis_pkg::CNT_W'(CAP);
	localparam logic [mtis_pkg::CNT_W-1:0] MIN_N = 9'd2;

	// Sequencer states.
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CL0   = 3'd1;
	localparam logic [2:0] ST_CL1   = 3'd2;
	localparam logic [2:0] ST_SWEEP = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0]                   state_q;
	logic [mtis_pkg::CNT_W-1:0]   level_count_q;
	logic                         descending_q;
	logic [mtis_pkg::KEY_W-1:0]   key_q;
	logic [mtis_pkg::CNT_W-1:0]   cnt_q;
	logic [mtis_pkg::CNT_W-1:0]   hits_q;
	logic                         out_valid_q;
	logic [mtis_pkg::IDX_W-1:0]   out_data_q;

	logic [mtis_pkg::CNT_W-1:0]   n_eff;
	logic [mtis_pkg::CNT_W-1:0]   n_less2;
	logic [IW-1:0]                top_w;
	logic [IW-1:0]                cnt_w;
	logic [IW-1:0]                idx_w;
	logic                         in_acc;
	logic                         is_query;
	logic [mtis_pkg::IDX_W-1:0]   in_index;
	logic [mtis_pkg::KEY_W-1:0]   in_key;
	logic                         wr_en;
	logic                         rd_en;
	logic [AW-1:0]                rd_addr;
	logic [mtis_pkg::KEY_W-1:0]   rd_data;
	mtis_pkg::cmp_res_t           cmp;
	logic                         hit;
	logic                         out_free;
	logic [mtis_pkg::CNT_W-1:0]   hits_m1;
	logic [mtis_pkg::IDX_W-1:0]   result;

	// Unpack the request.
	assign in_index = s_tdata[7:0];
	assign in_key = s_tdata[70:8];
	assign is_query = (s_tuser[0] == mtis_pkg::OP_QUERY);
	assign s_tready = (state_q == ST_IDLE);
	assign in_acc = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	// Effective level count saturated into 2..min(MAX_LEVELS, 256).
	always_comb begin
		n_eff = level_count_q;
		if (n_eff < MIN_N) begin
			n_eff = MIN_N;
		end
		if (n_eff > CAP_N) begin
			n_eff = CAP_N;
		end
	end
	assign n_less2 = n_eff - MIN_N;

	// Address arithmetic in a width that holds both the count and the depth.
	assign top_w = IW'(n_less2);
	assign cnt_w = IW'(cnt_q);
	assign idx_w = IW'(in_index);

	// Loads beyond the table are dropped.
	assign wr_en = in_acc && !is_query && (idx_w < IW'(MAX_LEVELS));

	// Read address: entry 0 at acceptance and before the sweep, top bound in
	// the first clamp step, the sweep counter afterwards.
	always_comb begin
		rd_en = 1'b0;
		rd_addr = '0;
		unique case (state_q)
			ST_IDLE: begin
				rd_en = in_acc && is_query;
			end
			ST_CL0: begin
				rd_en = 1'b1;
				rd_addr = top_w[AW-1:0];
			end
			ST_CL1: begin
				rd_en = 1'b1;
			end
			ST_SWEEP: begin
				rd_en = (cnt_q < n_eff);
				rd_addr = cnt_w[AW-1:0];
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	mtis_table #(
		.DEPTH(MAX_LEVELS),
		.AW(AW)
	) u_table (
		.clk(clk),
		.wr_en(wr_en),
		.wr_addr(idx_w[AW-1:0]),
		.wr_data(in_key),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	mtis_cmp u_cmp (
		.entry(rd_data),
		.key(key_q),
		.res(cmp)
	);

	// An entry counts when it lies at or below the key, or at or above it
	// for a descending table.
	assign hit = descending_q ? !cmp.lt : !cmp.gt;

	// Final index: count minus one, saturated into 0..n-2.
	always_comb begin
		hits_m1 = hits_q - 9'd1;
		if (hits_q == '0) begin
			result = '0;
		end else if (hits_m1 > n_less2) begin
			result = n_less2[mtis_pkg::IDX_W-1:0];
		end else begin
			result = hits_m1[mtis_pkg::IDX_W-1:0];
		end
	end

	assign out_free = !out_valid_q || m_tready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_count_q <= mtis_pkg::LEVEL_COUNT_RESET;
			descending_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == mtis_pkg::CFG_LEVEL_COUNT) begin
				level_count_q <= cfg_data;
			end else if (cfg_index == mtis_pkg::CFG_DESCENDING) begin
				descending_q <= cfg_data[0];
			end
		end
	end

	// Sequencer control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && is_query) begin
						state_q <= ST_CL0;
					end
				end
				ST_CL0: begin
					state_q <= ST_CL1;
				end
				ST_CL1: begin
					state_q <= ST_SWEEP;
				end
				ST_SWEEP: begin
					if (cnt_q == n_eff) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Working key, clamps and hit count.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				key_q <= in_key;
			end
			ST_CL0: begin
				// Clamp to entry 0.
				if (descending_q ? cmp.lt : cmp.gt) begin
					key_q <= rd_data;
				end
			end
			ST_CL1: begin
				// Clamp to entry n-2.
				if (descending_q ? cmp.gt : cmp.lt) begin
					key_q <= rd_data;
				end
				cnt_q <= 9'd1;
				hits_q <= '0;
			end
			ST_SWEEP: begin
				if (hit) begin
					hits_q <= hits_q + 9'd1;
				end
				cnt_q <= cnt_q + 9'd1;
			end
			default: begin
				key_q <= key_q;
			end
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_data_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_data_q;

endmodule

// ----- sv/mtis_checker.sv -----
// Port-level checks for the interval search block, bound to its top level.
`timescale 1ns / 1ps

module mtis_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic [0:0] s_tuser,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata
);

	// A stalled result holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	// The interval index never reaches the top code.
	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata != 8'd255)
		else $error("interval index out of range");

	// A query keeps the block busy in the following cycle.
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser[0] |=> !s_tready)
		else $error("accepted a request during a search");

	// A load completes at once and leaves the block ready.
	a_load_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !s_tuser[0] |=> s_tready)
		else $error("load left the block busy");

endmodule

bind monotone_table_interval_search mtis_checker u_mtis_checker (.*);
